/* sv/ush_pkg.sv */
package ush_pkg;

    localparam int BYTE_W = 8;
    localparam int HASH_W = 16;
    localparam int SIZE_W = 17;
    localparam int PROD_W = 32;
    localparam int CNT_W  = $clog2(PROD_W);

    localparam logic [HASH_W-1:0] ALPHA_INIT = HASH_W'(31415);
    localparam logic [HASH_W-1:0] BETA       = HASH_W'(27183);
    localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);
    localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(65536);

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] r;
        r = s;
        if (s < SIZE_MIN) begin
            r = SIZE_MIN;
        end else if (s > SIZE_MAX) begin
            r = SIZE_MAX;
        end
        return r;
    endfunction

endpackage

/* sv/ush_rem.sv */
module ush_rem (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ush_pkg::PROD_W-1:0]    i_dividend,
    input  logic [ush_pkg::SIZE_W-1:0]    i_modulus,
    output logic                          o_done,
    output logic [ush_pkg::HASH_W-1:0]    o_rem
);
    import ush_pkg::*;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [PROD_W-1:0] r_dvd, n_dvd;
    logic [HASH_W-1:0] r_rem, n_rem;
    logic [SIZE_W-1:0] r_mod, n_mod;
    logic [SIZE_W-1:0] w_trial;
    logic [SIZE_W-1:0] w_diff;

    // one dividend bit per cycle, restoring step
    assign w_trial = {r_rem, r_dvd[PROD_W-1]};
    assign w_diff  = w_trial - r_mod;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        n_mod  = r_mod;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_dvd  = i_dividend;
            n_rem  = '0;
            n_mod  = i_modulus;
        end else if (r_busy) begin
            n_dvd = {r_dvd[PROD_W-2:0], 1'b0};
            n_rem = (w_trial >= r_mod) ? w_diff[HASH_W-1:0] : w_trial[HASH_W-1:0];
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(PROD_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_mod <= n_mod;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

/* sv/universal_string_hash_unit.sv */
// channel   direction  valid     stall     payload
// input     in         i_valid   o_stall   i_key_byte[7:0]
// result    out        o_valid   i_stall   o_bucket_index[15:0]
// config    in         i_cfg_we  -         i_cfg_data[16:0]
//
// A nonzero byte is handled in steps: both products are registered when the
// byte is taken, the two remainder units are loaded, they run their bit-serial
// restoring reduction, and the remainders are written back.
// A zero byte loads the output register.
// Synchronous active-low reset; table_size resets to 65536.
// o_stall is high while a byte is in work, and while a result is held by i_stall.
module universal_string_hash_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [ush_pkg::BYTE_W-1:0]    i_key_byte,
    output logic                          o_stall,
    output logic                          o_valid,
    output logic [ush_pkg::HASH_W-1:0]    o_bucket_index,
    input  logic                          i_stall,
    input  logic                          i_cfg_we,
    input  logic [ush_pkg::SIZE_W-1:0]    i_cfg_data
);
    import ush_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;
    localparam logic [1:0] S_REM  = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [SIZE_W-1:0] r_size;
    logic [HASH_W-1:0] r_hash, n_hash;
    logic [HASH_W-1:0] r_mult, n_mult;
    logic [PROD_W-1:0] r_prod_h;
    logic [PROD_W-1:0] r_prod_m;
    logic              r_out_valid, n_out_valid;
    logic [HASH_W-1:0] r_out_idx, n_out_idx;
    logic              w_acc;
    logic              w_start;
    logic [SIZE_W-1:0] w_size;
    logic              w_done_h, w_done_m;
    logic [HASH_W-1:0] w_rem_h, w_rem_m;

    assign o_stall = !i_rst_n || (r_state != S_IDLE) || (r_out_valid && i_stall);
    assign w_acc   = i_valid && !o_stall;
    assign w_start = (r_state == S_LOAD);
    assign w_size  = eff_size(r_size);

    always_comb begin
        n_state     = r_state;
        n_hash      = r_hash;
        n_mult      = r_mult;
        n_out_valid = r_out_valid && i_stall;
        n_out_idx   = r_out_idx;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (i_key_byte == '0) begin
                        n_out_valid = 1'b1;
                        n_out_idx   = r_hash;
                        n_hash      = '0;
                        n_mult      = ALPHA_INIT;
                    end else begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                n_state = S_REM;
            end
            S_REM: begin
                if (w_done_h && w_done_m) begin
                    n_hash  = w_rem_h;
                    n_mult  = w_rem_m;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_size      <= SIZE_MAX;
            r_hash      <= '0;
            r_mult      <= ALPHA_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hash      <= n_hash;
            r_mult      <= n_mult;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_size <= i_cfg_data;
            end
        end
        r_out_idx <= n_out_idx;
        if (w_acc) begin
            r_prod_h <= PROD_W'(r_mult) * PROD_W'(r_hash) + PROD_W'(i_key_byte);
            r_prod_m <= PROD_W'(r_mult) * PROD_W'(BETA);
        end
    end

    ush_rem u_rem_hash (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (r_prod_h),
        .i_modulus  (w_size),
        .o_done     (w_done_h),
        .o_rem      (w_rem_h)
    );

    ush_rem u_rem_mult (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (r_prod_m),
        .i_modulus  (w_size - SIZE_W'(1)),
        .o_done     (w_done_m),
        .o_rem      (w_rem_m)
    );

    assign o_valid        = r_out_valid;
    assign o_bucket_index = r_out_idx;

endmodule

/* sv/ush_checker.sv */
module ush_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [ush_pkg::BYTE_W-1:0]    i_key_byte,
    input  logic                          o_stall,
    input  logic                          o_valid,
    input  logic [ush_pkg::HASH_W-1:0]    o_bucket_index,
    input  logic                          i_stall,
    input  logic                          i_cfg_we,
    input  logic [ush_pkg::SIZE_W-1:0]    i_cfg_data
);
    import ush_pkg::*;

    logic w_in_xfer;
    assign w_in_xfer = i_valid && !o_stall;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_bucket_index))
        else $error("result changed while stalled");

    a_rise_from_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_in_xfer && (i_key_byte == '0)))
        else $error("result without a key end transfer");

    a_end_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer && (i_key_byte == '0) |=> o_valid)
        else $error("key end transfer gave no result");

    a_byte_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer && (i_key_byte != '0) |=> o_stall [*34])
        else $error("input taken while a byte is in work");

endmodule

bind universal_string_hash_unit ush_checker u_ush_checker (.*);
